/* src/fbdr_pkg.sv */
// ----------------------------------------------------------------------------
// fbdr_pkg
// Shared types, codes and the CRC-32 byte step for the firmware block
// download receiver.
// ----------------------------------------------------------------------------
package fbdr_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       flash_ok;
  } fbdr_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] flash_address;
    logic [31:0] program_data;
    logic        last;
  } fbdr_out_t;

  // Up to two results per input transaction enter the result queue at once.
  typedef struct packed {
    logic [1:0] n;
    fbdr_out_t  e0;
    fbdr_out_t  e1;
  } fbdr_push_t;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_FLASH   = 2'd2;
  localparam logic [1:0] OP_START   = 2'd3;

  localparam logic [2:0] K_READY     = 3'd0;
  localparam logic [2:0] K_BADSIZE   = 3'd1;
  localparam logic [2:0] K_ERASE     = 3'd2;
  localparam logic [2:0] K_PROG      = 3'd3;
  localparam logic [2:0] K_ERASEFAIL = 3'd4;
  localparam logic [2:0] K_OK        = 3'd5;
  localparam logic [2:0] K_RESEND    = 3'd6;
  localparam logic [2:0] K_DONE      = 3'd7;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_MAX  = 1'b1;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] BASE_RESET = 32'h08004000;
  localparam logic [24:0] MAX_RESET  = 25'(256 * 1024 - 16 * 1024);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

/* src/fbdr_store.sv */
// ----------------------------------------------------------------------------
// fbdr_store
// Block buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbdr_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [31:0]   wd,
  input  logic [AW-1:0] ra,
  output logic [31:0]   rd
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

/* src/fbdr_out_fifo.sv */
// ----------------------------------------------------------------------------
// fbdr_out_fifo
// Four-entry result queue, takes up to two results a cycle, gives one while out_stall is low.
// ----------------------------------------------------------------------------
module fbdr_out_fifo import fbdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fbdr_push_t push,
  input  logic       out_stall,
  output logic       out_valid,
  output fbdr_out_t  out_data,
  output logic [2:0] level
);

  fbdr_out_t  q_r [4];
  logic [1:0] head_r, tail_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_r + {1'b0, pop};
      tail_r <= tail_r + push.n;
      cnt_r  <= cnt_r + {1'b0, push.n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[tail_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      q_r[tail_r + 2'd1] <= push.e1;
    end
  end

endmodule

/* src/firmware_block_download_receiver_top.sv */
// ----------------------------------------------------------------------------
// firmware_block_download_receiver_top
// Firmware download receiver: size, page erase, CRC-checked data blocks,
// word programming.
// ----------------------------------------------------------------------------
// The block accepts one input transaction per cycle while in_stall is low.
// The results of a transaction are registered in a result stage and from
// there enter a four-entry result queue, whose head is driven on the output.
// in_stall rises only when the queue, counting the results still held in the
// result stage, has room for fewer than two more. A data block is written
// into an internal buffer of PAGE_BYTES/4 words (one word write per four
// bytes, and one for a last partial word). The program words are read back
// from it one per flash status, and the registered read data lines up with
// the result stage. Configuration is taken at any time (cfg_ready is always
// high) and must be written while idle.
module firmware_block_download_receiver_top import fbdr_pkg::*; #(
  parameter int PAGE_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fbdr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output fbdr_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int DEPTH = PAGE_BYTES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int LEN_W = $clog2(PAGE_BYTES + 1);
  localparam int WIW   = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIZE, PH_ERASE, PH_LEN, PH_CRC, PH_DATA, PH_PROG
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [31:0]       fs_r, fs_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [24:0]       size_r, size_nxt;
  logic [24:0]       off_r, off_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [31:0]       exp_r, exp_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       tgt_r, tgt_nxt;
  logic [WIW-1:0]    widx_r, widx_nxt;
  logic [31:0]       wacc_r, wacc_nxt;
  logic [31:0]       base_r;
  logic [24:0]       max_r;

  // result stage
  logic [1:0]  p1_n_r, n_c;
  logic [2:0]  p1_k0_r, k0_c, p1_k1_r, k1_c;
  logic [31:0] p1_addr_r, addr_c;
  logic [3:0]  p1_mask_r, mask_c;
  logic        p1_mem_r, mem_c;
  logic        p1_fwd_r;
  logic [31:0] p1_fwd_data_r;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   rd;
  logic          accept;
  logic [2:0]    level;
  fbdr_push_t    push;
  logic [31:0]   raw;

  logic [31:0]      fs_v, crc_v, v_ext;
  logic [25:0]      off_e;
  logic [32:0]      len_end;
  logic [LEN_W-1:0] cnt_inc;
  logic [WIW-1:0]   wi;

  function automatic logic [3:0] mask_of(input logic [WIW-1:0] w, input logic [LEN_W-1:0] l);
    logic [3:0]  m;
    logic [31:0] p;
    for (int i = 0; i < 4; i++) begin
      p = {30'(w), 2'b00} + 32'(i);
      m[i] = (p < 32'(l));
    end
    return m;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = ({1'b0, level} + {2'b00, p1_n_r}) > 4'd2;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    fs_nxt    = fs_r;
    cnt_nxt   = cnt_r;
    size_nxt  = size_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    exp_nxt   = exp_r;
    crc_nxt   = crc_r;
    tgt_nxt   = tgt_r;
    widx_nxt  = widx_r;
    wacc_nxt  = wacc_r;
    n_c       = 2'd0;
    k0_c      = K_READY;
    k1_c      = K_DONE;
    addr_c    = '0;
    mask_c    = '0;
    mem_c     = 1'b0;
    we        = 1'b0;
    wa        = cnt_r[AW+1:2];
    ra        = '0;
    fs_v      = {in_data.rx_byte, fs_r[31:8]};
    crc_v     = crc_byte(crc_r, in_data.rx_byte);
    v_ext     = fs_v;
    off_e     = {1'b0, off_r} + 26'(PAGE_BYTES);
    len_end   = {8'd0, off_r} + {1'b0, fs_v};
    cnt_inc   = cnt_r + LEN_W'(1);
    wi        = widx_r + WIW'(1);
    if (accept) begin
      unique case (in_data.operation)
        OP_START: begin
          phase_nxt = PH_SIZE;
          cnt_nxt   = '0;
          fs_nxt    = '0;
          size_nxt  = '0;
          off_nxt   = '0;
          n_c       = 2'd1;
          k0_c      = K_READY;
        end
        OP_TIMEOUT: begin
          if (phase_r == PH_SIZE) begin
            phase_nxt = PH_IDLE;
            n_c       = 2'd1;
            k0_c      = K_BADSIZE;
          end else if (phase_r == PH_LEN || phase_r == PH_CRC || phase_r == PH_DATA) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
            fs_nxt    = '0;
            n_c       = 2'd1;
            k0_c      = K_RESEND;
          end
        end
        OP_FLASH: begin
          if (phase_r == PH_ERASE) begin
            if (!in_data.flash_ok) begin
              phase_nxt = PH_IDLE;
              n_c       = 2'd1;
              k0_c      = K_ERASEFAIL;
            end else if (off_e < {1'b0, size_r}) begin
              off_nxt = off_e[24:0];
              n_c     = 2'd1;
              k0_c    = K_ERASE;
              addr_c  = base_r + 32'(off_e);
            end else begin
              off_nxt   = '0;
              phase_nxt = PH_LEN;
              cnt_nxt   = '0;
              fs_nxt    = '0;
            end
          end else if (phase_r == PH_PROG) begin
            if (!in_data.flash_ok) begin
              phase_nxt = PH_LEN;
              cnt_nxt   = '0;
              fs_nxt    = '0;
              n_c       = 2'd1;
              k0_c      = K_RESEND;
            end else if ({wi, 2'b00} < (WIW + 2)'(len_r)) begin
              widx_nxt = wi;
              tgt_nxt  = tgt_r + 32'd4;
              n_c      = 2'd1;
              k0_c     = K_PROG;
              addr_c   = tgt_r + 32'd4;
              ra       = wi[AW-1:0];
              mem_c    = 1'b1;
              mask_c   = mask_of(wi, len_r);
            end else begin
              off_nxt   = off_r + 25'(len_r);
              phase_nxt = PH_LEN;
              cnt_nxt   = '0;
              fs_nxt    = '0;
              n_c       = 2'd1;
              k0_c      = K_OK;
              if ((off_r + 25'(len_r)) >= size_r) begin
                phase_nxt = PH_IDLE;
                n_c       = 2'd2;
                k1_c      = K_DONE;
              end
            end
          end
        end
        OP_BYTE: begin
          if (phase_r == PH_SIZE || phase_r == PH_LEN || phase_r == PH_CRC) begin
            if (cnt_r == LEN_W'(3)) begin
              cnt_nxt = '0;
              fs_nxt  = '0;
              if (phase_r == PH_SIZE) begin
                if (v_ext == 32'd0 || v_ext > 32'(max_r)) begin
                  phase_nxt = PH_IDLE;
                  n_c       = 2'd1;
                  k0_c      = K_BADSIZE;
                end else begin
                  size_nxt  = v_ext[24:0];
                  off_nxt   = '0;
                  phase_nxt = PH_ERASE;
                  n_c       = 2'd1;
                  k0_c      = K_ERASE;
                  addr_c    = base_r;
                end
              end else if (phase_r == PH_LEN) begin
                if (v_ext == 32'd0 || v_ext > 32'(PAGE_BYTES) || len_end > 33'(size_r)) begin
                  n_c  = 2'd1;
                  k0_c = K_RESEND;
                end else begin
                  len_nxt   = v_ext[LEN_W-1:0];
                  phase_nxt = PH_CRC;
                end
              end else begin
                exp_nxt   = v_ext;
                crc_nxt   = CRC_INIT;
                phase_nxt = PH_DATA;
              end
            end else begin
              fs_nxt  = fs_v;
              cnt_nxt = cnt_inc;
            end
          end else if (phase_r == PH_DATA) begin
            unique case (cnt_r[1:0])
              2'd0:    wacc_nxt = {wacc_r[31:8], in_data.rx_byte};
              2'd1:    wacc_nxt = {wacc_r[31:16], in_data.rx_byte, wacc_r[7:0]};
              2'd2:    wacc_nxt = {wacc_r[31:24], in_data.rx_byte, wacc_r[15:0]};
              default: wacc_nxt = {in_data.rx_byte, wacc_r[23:0]};
            endcase
            crc_nxt = crc_v;
            cnt_nxt = cnt_inc;
            we      = (cnt_r[1:0] == 2'd3) || (cnt_inc == len_r);
            if (cnt_inc == len_r) begin
              cnt_nxt = '0;
              if (~crc_v != exp_r) begin
                phase_nxt = PH_LEN;
                fs_nxt    = '0;
                n_c       = 2'd1;
                k0_c      = K_RESEND;
              end else begin
                phase_nxt = PH_PROG;
                widx_nxt  = '0;
                tgt_nxt   = base_r + 32'(off_r);
                n_c       = 2'd1;
                k0_c      = K_PROG;
                addr_c    = base_r + 32'(off_r);
                ra        = '0;
                mem_c     = 1'b1;
                mask_c    = mask_of('0, len_r);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fs_r    <= '0;
      cnt_r   <= '0;
      size_r  <= '0;
      off_r   <= '0;
      len_r   <= '0;
      exp_r   <= '0;
      crc_r   <= CRC_INIT;
      tgt_r   <= '0;
      widx_r  <= '0;
      base_r  <= BASE_RESET;
      max_r   <= MAX_RESET;
      p1_n_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      fs_r    <= fs_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      exp_r   <= exp_nxt;
      crc_r   <= crc_nxt;
      tgt_r   <= tgt_nxt;
      widx_r  <= widx_nxt;
      p1_n_r  <= n_c;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BASE: base_r <= cfg_wdata;
          CFG_MAX:  max_r  <= cfg_wdata[24:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wacc_r        <= wacc_nxt;
    p1_k0_r       <= k0_c;
    p1_k1_r       <= k1_c;
    p1_addr_r     <= addr_c;
    p1_mask_r     <= mask_c;
    p1_mem_r      <= mem_c;
    // forward the word written in the same cycle as the read
    p1_fwd_r      <= we && (wa == ra);
    p1_fwd_data_r <= wacc_nxt;
  end

  fbdr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wacc_nxt),
    .ra  (ra),
    .rd  (rd)
  );

  always_comb begin
    raw = p1_fwd_r ? p1_fwd_data_r : rd;
    push.n  = p1_n_r;
    push.e0.kind          = p1_k0_r;
    push.e0.flash_address = p1_addr_r;
    push.e0.program_data  = '0;
    if (p1_mem_r) begin
      for (int i = 0; i < 4; i++) begin
        push.e0.program_data[8*i +: 8] = p1_mask_r[i] ? raw[8*i +: 8] : 8'hFF;
      end
    end
    push.e0.last          = (p1_n_r == 2'd1);
    push.e1.kind          = p1_k1_r;
    push.e1.flash_address = '0;
    push.e1.program_data  = '0;
    push.e1.last          = 1'b1;
  end

  fbdr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .level     (level)
  );

  a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.operation == OP_START |=> p1_n_r == 2'd1 && p1_k0_r == K_READY)
    else $error("start did not answer ready");

  a_mem_is_prog: assert property (@(posedge clk) disable iff (!rst_n)
    p1_mem_r && p1_n_r != 2'd0 |-> p1_k0_r == K_PROG)
    else $error("buffer read without program result");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, level} + {2'b00, p1_n_r}) <= 4'd4)
    else $error("result queue overflow");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("results after reset");

endmodule
